/* src/arp_pkg.sv */
`default_nettype none

package arp_pkg;

  // coordinate width of the block, sizes are one bit narrower
  localparam int unsigned COORD_BITS = 16;
  localparam int unsigned SIZE_BITS  = COORD_BITS - 1;
  // internal sums: room for a coordinate plus three sizes
  localparam int unsigned WIDE_BITS  = COORD_BITS + 2;
  localparam int unsigned AREA_BITS  = 2 * SIZE_BITS;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic        [SIZE_BITS-1:0]  size_t;
  typedef logic signed [WIDE_BITS-1:0]  wide_t;
  typedef logic        [AREA_BITS-1:0]  ovl_t;

  // configuration register indexes
  localparam int unsigned CFG_IDX_BITS = 3;
  typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_AREA_LEFT   = 3'd0;
  localparam cfg_idx_t REG_AREA_TOP    = 3'd1;
  localparam cfg_idx_t REG_AREA_WIDTH  = 3'd2;
  localparam cfg_idx_t REG_AREA_HEIGHT = 3'd3;
  localparam cfg_idx_t REG_SPACING     = 3'd4;

  localparam size_t AREA_WIDTH_RST  = SIZE_BITS'(1920);
  localparam size_t AREA_HEIGHT_RST = SIZE_BITS'(1080);

  // placement side, also the priority order of the candidates
  typedef enum logic [1:0] {
    SIDE_RIGHT = 2'd0,
    SIDE_LEFT  = 2'd1,
    SIDE_BELOW = 2'd2,
    SIDE_ABOVE = 2'd3
  } side_e;

  localparam int unsigned N_SIDES = 4;

  // one axis of a candidate against the area
  typedef struct packed {
    logic  enclosed;
    size_t len;
  } span_t;

  // follower size and clamp limits carried along the pipeline
  typedef struct packed {
    size_t w;
    size_t h;
    wide_t xhi;
    wide_t yhi;
  } geom_t;

  typedef wide_t pos4_t [N_SIDES];

  function automatic wide_t clamp_w(input wide_t v, input wide_t lo, input wide_t hi);
    wide_t r;
    if (v < lo) begin
      r = lo;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* src/arp_in_if.sv */
`default_nettype none

interface arp_in_if;
  import arp_pkg::*;

  logic   valid;
  logic   ready;
  coord_t leader_left;
  coord_t leader_top;
  size_t  leader_width;
  size_t  leader_height;
  size_t  wanted_width;
  size_t  wanted_height;

  modport source (
    output valid, leader_left, leader_top, leader_width, leader_height,
    output wanted_width, wanted_height,
    input  ready
  );

  modport sink (
    input  valid, leader_left, leader_top, leader_width, leader_height,
    input  wanted_width, wanted_height,
    output ready
  );
endinterface

`default_nettype wire

/* src/arp_out_if.sv */
`default_nettype none

interface arp_out_if;
  import arp_pkg::*;

  logic       valid;
  logic       ready;
  coord_t     place_left;
  coord_t     place_top;
  size_t      place_width;
  size_t      place_height;
  logic [1:0] side;
  logic       fits;

  modport source (
    output valid, place_left, place_top, place_width, place_height, side, fits,
    input  ready
  );

  modport sink (
    input  valid, place_left, place_top, place_width, place_height, side, fits,
    output ready
  );
endinterface

`default_nettype wire

/* src/arp_span.sv */
`default_nettype none

module arp_span (
  input  wire arp_pkg::wide_t lo_i,
  input  wire arp_pkg::wide_t hi_i,
  input  wire arp_pkg::wide_t area_lo_i,
  input  wire arp_pkg::wide_t area_hi_i,
  output arp_pkg::span_t      span_o
);
  import arp_pkg::*;

  wide_t lo_max;
  wide_t hi_min;
  wide_t diff;

  // intersection of [lo, hi) with the area on this axis
  always_comb begin
    lo_max = (lo_i > area_lo_i) ? lo_i : area_lo_i;
    hi_min = (hi_i < area_hi_i) ? hi_i : area_hi_i;
    diff   = hi_min - lo_max;
    span_o.enclosed = (lo_i >= area_lo_i) && (hi_i <= area_hi_i);
    span_o.len      = diff[WIDE_BITS-1] ? '0 : diff[SIZE_BITS-1:0];
  end

endmodule

`default_nettype wire

/* src/adjacent_rect_placement_core.sv */
// Places a follower rectangle next to a leader rectangle inside the
// configured area, trying right, left, below and above in that order.
//
// Channels: in_if carries one item (leader rectangle and wanted size),
// out_if returns one item per input (placement, side, fits). Both are
// valid/ready; an item moves on a clock edge where both are high.
// The configuration port writes one register per cycle with cfg_we_i;
// write it only while no item is in flight.
//
// A result is valid once its item has passed all eight register stages
// (size prep, side offsets, edge sums, overlap spans, multiply, pair
// compare, final choice, clamp/output register).
// Throughput: one item per cycle while the receiver takes results.
//
// Reset clears all stage valid bits and loads the area registers with
// left 0, top 0, width 1920, height 1080, spacing 0.
// When the receiver stalls, a stage holds its item while the next holds;
// empty stages fill, so in_if.ready drops only once all eight are full.
`default_nettype none

module adjacent_rect_placement_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire arp_pkg::cfg_idx_t cfg_idx_i,
  input  wire arp_pkg::coord_t   cfg_data_i,
  arp_in_if.sink                 in_if,
  arp_out_if.source              out_if
);
  import arp_pkg::*;

  localparam int unsigned N_STG = 8;

  // configuration registers
  coord_t area_left_q, area_top_q;
  size_t  area_width_q, area_height_q, spacing_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      area_left_q   <= '0;
      area_top_q    <= '0;
      area_width_q  <= AREA_WIDTH_RST;
      area_height_q <= AREA_HEIGHT_RST;
      spacing_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_AREA_LEFT:   area_left_q   <= cfg_data_i;
        REG_AREA_TOP:    area_top_q    <= cfg_data_i;
        REG_AREA_WIDTH:  area_width_q  <= cfg_data_i[SIZE_BITS-1:0];
        REG_AREA_HEIGHT: area_height_q <= cfg_data_i[SIZE_BITS-1:0];
        REG_SPACING:     spacing_q     <= cfg_data_i[SIZE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // area extents, zero size counts as one
  size_t area_w, area_h;
  wide_t area_lx, area_ty, area_rx, area_by;

  always_comb begin
    area_w  = (area_width_q  == '0) ? SIZE_BITS'(1) : area_width_q;
    area_h  = (area_height_q == '0) ? SIZE_BITS'(1) : area_height_q;
    area_lx = wide_t'(area_left_q);
    area_ty = wide_t'(area_top_q);
    area_rx = area_lx + wide_t'(area_w);
    area_by = area_ty + wide_t'(area_h);
  end

  // stage valid bits and per-stage load enables
  logic [N_STG-1:0] stage_vld_q, stage_vld_d, stage_en;

  always_comb begin
    stage_en[N_STG-1] = !stage_vld_q[N_STG-1] || out_if.ready;
    for (int k = N_STG - 2; k >= 0; k--) begin
      stage_en[k] = !stage_vld_q[k] || stage_en[k+1];
    end
    stage_vld_d[0] = stage_en[0] ? in_if.valid : stage_vld_q[0];
    for (int k = 1; k < N_STG; k++) begin
      stage_vld_d[k] = stage_en[k] ? stage_vld_q[k-1] : stage_vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_vld_q <= '0;
    end else begin
      stage_vld_q <= stage_vld_d;
    end
  end

  assign in_if.ready = stage_en[0];

  // stage 1: follower size, far-side offsets and clamp limits
  coord_t s1_lx_q, s1_ly_q;
  wide_t  s1_c0x_q, s1_c2y_q, s1_lxg_q, s1_lyg_q;
  wide_t  s1_c0x_d, s1_c2y_d, s1_lxg_d, s1_lyg_d;
  geom_t  s1_geo_q, s1_geo_d;
  size_t  want_w, want_h;

  always_comb begin
    want_w = (in_if.wanted_width  == '0) ? SIZE_BITS'(1) : in_if.wanted_width;
    want_h = (in_if.wanted_height == '0) ? SIZE_BITS'(1) : in_if.wanted_height;
    s1_geo_d.w   = (want_w > area_w) ? area_w : want_w;
    s1_geo_d.h   = (want_h > area_h) ? area_h : want_h;
    s1_geo_d.xhi = area_rx - wide_t'(s1_geo_d.w);
    s1_geo_d.yhi = area_by - wide_t'(s1_geo_d.h);
    s1_c0x_d = wide_t'(in_if.leader_left) + wide_t'(in_if.leader_width)
             + wide_t'(spacing_q);
    s1_c2y_d = wide_t'(in_if.leader_top) + wide_t'(in_if.leader_height)
             + wide_t'(spacing_q);
    s1_lxg_d = wide_t'(in_if.leader_left) - wide_t'(spacing_q);
    s1_lyg_d = wide_t'(in_if.leader_top) - wide_t'(spacing_q);
  end

  always_ff @(posedge clk_i) begin
    if (stage_en[0]) begin
      s1_lx_q  <= in_if.leader_left;
      s1_ly_q  <= in_if.leader_top;
      s1_c0x_q <= s1_c0x_d;
      s1_c2y_q <= s1_c2y_d;
      s1_lxg_q <= s1_lxg_d;
      s1_lyg_q <= s1_lyg_d;
      s1_geo_q <= s1_geo_d;
    end
  end

  // stage 2: aligned cross coordinates and the four candidate corners
  pos4_t s2_cx_q, s2_cy_q, s2_cx_d, s2_cy_d;
  geom_t s2_geo_q;
  wide_t align_x, align_y;

  always_comb begin
    align_x = clamp_w(wide_t'(s1_lx_q), area_lx, s1_geo_q.xhi);
    align_y = clamp_w(wide_t'(s1_ly_q), area_ty, s1_geo_q.yhi);
    s2_cx_d[SIDE_RIGHT] = s1_c0x_q;
    s2_cy_d[SIDE_RIGHT] = align_y;
    s2_cx_d[SIDE_LEFT]  = s1_lxg_q - wide_t'(s1_geo_q.w);
    s2_cy_d[SIDE_LEFT]  = align_y;
    s2_cx_d[SIDE_BELOW] = align_x;
    s2_cy_d[SIDE_BELOW] = s1_c2y_q;
    s2_cx_d[SIDE_ABOVE] = align_x;
    s2_cy_d[SIDE_ABOVE] = s1_lyg_q - wide_t'(s1_geo_q.h);
  end

  always_ff @(posedge clk_i) begin
    if (stage_en[1]) begin
      s2_cx_q  <= s2_cx_d;
      s2_cy_q  <= s2_cy_d;
      s2_geo_q <= s1_geo_q;
    end
  end

  // stage 3: far edges of each candidate
  pos4_t s3_cx_q, s3_cy_q, s3_ex_q, s3_ey_q, s3_ex_d, s3_ey_d;
  geom_t s3_geo_q;

  always_comb begin
    for (int i = 0; i < N_SIDES; i++) begin
      s3_ex_d[i] = s2_cx_q[i] + wide_t'(s2_geo_q.w);
      s3_ey_d[i] = s2_cy_q[i] + wide_t'(s2_geo_q.h);
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en[2]) begin
      s3_cx_q  <= s2_cx_q;
      s3_cy_q  <= s2_cy_q;
      s3_ex_q  <= s3_ex_d;
      s3_ey_q  <= s3_ey_d;
      s3_geo_q <= s2_geo_q;
    end
  end

  // stage 4: per-axis containment and intersection length
  span_t s4_xs_q [N_SIDES];
  span_t s4_ys_q [N_SIDES];
  span_t s4_xs_d [N_SIDES];
  span_t s4_ys_d [N_SIDES];
  pos4_t s4_cx_q, s4_cy_q;
  geom_t s4_geo_q;

  for (genvar g = 0; g < N_SIDES; g++) begin : g_span
    arp_span u_span_x (
      .lo_i      (s3_cx_q[g]),
      .hi_i      (s3_ex_q[g]),
      .area_lo_i (area_lx),
      .area_hi_i (area_rx),
      .span_o    (s4_xs_d[g])
    );
    arp_span u_span_y (
      .lo_i      (s3_cy_q[g]),
      .hi_i      (s3_ey_q[g]),
      .area_lo_i (area_ty),
      .area_hi_i (area_by),
      .span_o    (s4_ys_d[g])
    );
  end

  always_ff @(posedge clk_i) begin
    if (stage_en[3]) begin
      s4_xs_q  <= s4_xs_d;
      s4_ys_q  <= s4_ys_d;
      s4_cx_q  <= s3_cx_q;
      s4_cy_q  <= s3_cy_q;
      s4_geo_q <= s3_geo_q;
    end
  end

  // stage 5: visible area of each candidate and full-fit flags
  ovl_t               s5_ov_q [N_SIDES];
  ovl_t               s5_ov_d [N_SIDES];
  logic [N_SIDES-1:0] s5_fit_q, s5_fit_d;
  pos4_t              s5_cx_q, s5_cy_q;
  geom_t              s5_geo_q;

  always_comb begin
    for (int i = 0; i < N_SIDES; i++) begin
      s5_ov_d[i]  = ovl_t'(s4_xs_q[i].len) * ovl_t'(s4_ys_q[i].len);
      s5_fit_d[i] = s4_xs_q[i].enclosed && s4_ys_q[i].enclosed;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en[4]) begin
      s5_ov_q  <= s5_ov_d;
      s5_fit_q <= s5_fit_d;
      s5_cx_q  <= s4_cx_q;
      s5_cy_q  <= s4_cy_q;
      s5_geo_q <= s4_geo_q;
    end
  end

  // stage 6: first fitting side, and pairwise best overlap (earlier wins ties)
  side_e s6_i01_q, s6_i23_q, s6_fit_side_q, s6_i01_d, s6_i23_d, s6_fit_side_d;
  ovl_t  s6_ov01_q, s6_ov23_q, s6_ov01_d, s6_ov23_d;
  logic  s6_fit_any_q;
  pos4_t s6_cx_q, s6_cy_q;
  geom_t s6_geo_q;

  always_comb begin
    s6_i01_d  = (s5_ov_q[SIDE_LEFT]  > s5_ov_q[SIDE_RIGHT]) ? SIDE_LEFT  : SIDE_RIGHT;
    s6_ov01_d = s5_ov_q[s6_i01_d];
    s6_i23_d  = (s5_ov_q[SIDE_ABOVE] > s5_ov_q[SIDE_BELOW]) ? SIDE_ABOVE : SIDE_BELOW;
    s6_ov23_d = s5_ov_q[s6_i23_d];
    if (s5_fit_q[SIDE_RIGHT]) begin
      s6_fit_side_d = SIDE_RIGHT;
    end else if (s5_fit_q[SIDE_LEFT]) begin
      s6_fit_side_d = SIDE_LEFT;
    end else if (s5_fit_q[SIDE_BELOW]) begin
      s6_fit_side_d = SIDE_BELOW;
    end else begin
      s6_fit_side_d = SIDE_ABOVE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en[5]) begin
      s6_i01_q      <= s6_i01_d;
      s6_i23_q      <= s6_i23_d;
      s6_ov01_q     <= s6_ov01_d;
      s6_ov23_q     <= s6_ov23_d;
      s6_fit_side_q <= s6_fit_side_d;
      s6_fit_any_q  <= |s5_fit_q;
      s6_cx_q       <= s5_cx_q;
      s6_cy_q       <= s5_cy_q;
      s6_geo_q      <= s5_geo_q;
    end
  end

  // stage 7: final choice of side
  side_e s7_side_q, s7_side_d;
  wide_t s7_x_q, s7_y_q;
  logic  s7_fits_q;
  geom_t s7_geo_q;

  always_comb begin
    if (s6_fit_any_q) begin
      s7_side_d = s6_fit_side_q;
    end else if (s6_ov23_q > s6_ov01_q) begin
      s7_side_d = s6_i23_q;
    end else begin
      s7_side_d = s6_i01_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en[6]) begin
      s7_side_q <= s7_side_d;
      s7_x_q    <= s6_cx_q[s7_side_d];
      s7_y_q    <= s6_cy_q[s7_side_d];
      s7_fits_q <= s6_fit_any_q;
      s7_geo_q  <= s6_geo_q;
    end
  end

  // stage 8: clamp a non-fitting placement into the area, output register
  wide_t  place_x_d, place_y_d;
  coord_t out_left_q, out_top_q;
  size_t  out_w_q, out_h_q;
  side_e  out_side_q;
  logic   out_fits_q;

  always_comb begin
    if (s7_fits_q) begin
      place_x_d = s7_x_q;
      place_y_d = s7_y_q;
    end else begin
      place_x_d = clamp_w(s7_x_q, area_lx, s7_geo_q.xhi);
      place_y_d = clamp_w(s7_y_q, area_ty, s7_geo_q.yhi);
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en[7]) begin
      out_left_q <= place_x_d[COORD_BITS-1:0];
      out_top_q  <= place_y_d[COORD_BITS-1:0];
      out_w_q    <= s7_geo_q.w;
      out_h_q    <= s7_geo_q.h;
      out_side_q <= s7_side_q;
      out_fits_q <= s7_fits_q;
    end
  end

  assign out_if.valid        = stage_vld_q[N_STG-1];
  assign out_if.place_left   = out_left_q;
  assign out_if.place_top    = out_top_q;
  assign out_if.place_width  = out_w_q;
  assign out_if.place_height = out_h_q;
  assign out_if.side         = out_side_q;
  assign out_if.fits         = out_fits_q;

  // input only backs up when every stage holds an item and the output stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_if.ready |-> ((&stage_vld_q) && !out_if.ready))
    else $error("input stalled with a free pipeline stage");

  // an item in the next-to-last stage reaches the output register when it loads
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stage_vld_q[N_STG-2] && stage_en[N_STG-1]) |=> stage_vld_q[N_STG-1])
    else $error("item dropped between choice and output stage");

  // a stalled result stays valid and unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && !out_if.ready) |=>
      out_if.valid &&
      $stable({out_left_q, out_top_q, out_w_q, out_h_q, out_side_q, out_fits_q}))
    else $error("stalled result changed");

  // result size is at least one and no larger than the area
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> (out_w_q != '0) && (out_h_q != '0) &&
                     (out_w_q <= area_w) && (out_h_q <= area_h))
    else $error("placement size out of range");

endmodule

`default_nettype wire
